### hw/rtl/pwlc_pkg.sv
package pwlc_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int LEVEL_W        = 8;
    localparam int INDEX_W        = 4;
    localparam int COUNT_W        = 5;
    localparam int PROD_W         = 2 * LEVEL_W;
    localparam int PAIR_W         = 2 * LEVEL_W;
    localparam int DIV_STEP_W     = $clog2(PROD_W + 1);

    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
        logic              rem_nz;
    } t_div_res;

endpackage

### hw/rtl/piecewise_linear_curve_lut.sv
// Tone-curve lookup over a table of control points (x, y).
// Input channel (i_in_valid / o_in_stall): opcode 0 loads point_x/point_y into
// slot point_index and gives no result; opcode 1 maps query_value through the
// curve built from the first points_in_use points, clamped to 2..MAX_POINTS. Output
// channel (o_out_valid / i_out_stall) carries lut_value and the clamped flag.
// Config channel (i_cfg_valid / o_cfg_ready) writes points_in_use; ready is
// always high, and writes belong to idle periods.
// Points live in one RAM with a registered read; the search reads one point per
// cycle. An evaluate that resolves at a point without interpolation goes from
// the search to the output handoff; one that interpolates passes through a
// multiply state, a 16-step serial divide and the output handoff. The next item
// is taken once the engine is back in idle; one item is in work at a time.
// The finished result sits in an output register, so the next item is taken
// while it waits; a stall holds it and, once a second result is ready, the
// engine waits with o_in_stall high.
// Reset (synchronous, active low) clears control state and sets
// points_in_use to 2; the point table is undefined until loaded.
module piecewise_linear_curve_lut #(
    parameter int MAX_POINTS = pwlc_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [pwlc_pkg::INDEX_W-1:0]        i_point_index,
    input  logic [pwlc_pkg::LEVEL_W-1:0]        i_point_x,
    input  logic [pwlc_pkg::LEVEL_W-1:0]        i_point_y,
    input  logic [pwlc_pkg::LEVEL_W-1:0]        i_query_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pwlc_pkg::LEVEL_W-1:0]        o_lut_value,
    output logic                                o_clamped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwlc_pkg::COUNT_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int LW = pwlc_pkg::LEVEL_W;
    localparam int SW = pwlc_pkg::PROD_W + 2;

    pwlc_pkg::t_state r_state, n_state;

    logic [pwlc_pkg::COUNT_W-1:0] r_points_in_use;
    logic [AW-1:0]                r_j, n_j;
    logic [AW-1:0]                r_last, n_last;
    logic [LW-1:0]                r_v, n_v;
    logic [LW-1:0]                r_x0, n_x0, r_y0, n_y0;
    logic [LW-1:0]                r_x1, n_x1, r_y1, n_y1;
    logic [LW-1:0]                r_res, n_res;
    logic                         r_res_clamp, n_res_clamp;
    logic                         r_out_valid, n_out_valid;
    logic [LW-1:0]                r_lut_value, n_lut_value;
    logic                         r_clamped, n_clamped;

    logic                         in_acc;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [pwlc_pkg::PAIR_W-1:0]  ram_rdata;
    logic [LW-1:0]                rx, ry;
    logic [AW-1:0]                last_sel;

    logic                         div_start;
    logic [pwlc_pkg::PROD_W-1:0]  prod;
    logic [LW-1:0]                dv, dy_mag, dx;
    logic                         dy_neg;
    pwlc_pkg::t_div_res           div_res;
    logic signed [SW-1:0]         interp;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != pwlc_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign ram_we    = in_acc && (i_opcode == pwlc_pkg::OPC_LOAD)
                       && (int'(i_point_index) < MAX_POINTS);
    assign ram_waddr = AW'(i_point_index);
    assign rx        = ram_rdata[pwlc_pkg::PAIR_W-1:LW];
    assign ry        = ram_rdata[LW-1:0];

    pwlc_ram #(
        .WIDTH (pwlc_pkg::PAIR_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // segment product: |v - x0| * |y1 - y0|, sign kept apart
    assign dv     = r_v - r_x0;
    assign dx     = r_x1 - r_x0;
    assign dy_neg = (r_y1 < r_y0);
    assign dy_mag = dy_neg ? (r_y0 - r_y1) : (r_y1 - r_y0);
    assign prod   = dv * dy_mag;

    pwlc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_divisor  (dx),
        .o_res      (div_res)
    );

    // floor for a negative slope: -(q + (rem != 0))
    always_comb begin
        if (dy_neg) begin
            interp = $signed({{(SW-LW){1'b0}}, r_y0})
                     - $signed({2'b00, div_res.quotient})
                     - $signed({{(SW-1){1'b0}}, div_res.rem_nz});
        end else begin
            interp = $signed({{(SW-LW){1'b0}}, r_y0})
                     + $signed({2'b00, div_res.quotient});
        end
    end

    // index of the last used point
    always_comb begin
        if (r_points_in_use < pwlc_pkg::COUNT_W'(2)) begin
            last_sel = AW'(1);
        end else if (int'(r_points_in_use) > MAX_POINTS) begin
            last_sel = AW'(MAX_POINTS - 1);
        end else begin
            last_sel = AW'(r_points_in_use - 1'b1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_last      = r_last;
        n_v         = r_v;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_res       = r_res;
        n_res_clamp = r_res_clamp;
        n_out_valid = r_out_valid && i_out_stall;
        n_lut_value = r_lut_value;
        n_clamped   = r_clamped;
        ram_raddr   = r_j;
        div_start   = 1'b0;

        case (r_state)
            pwlc_pkg::ST_IDLE: begin
                ram_raddr = '0;
                if (in_acc && (i_opcode == pwlc_pkg::OPC_EVAL)) begin
                    n_j     = '0;
                    n_last  = last_sel;
                    n_v     = i_query_value;
                    n_state = pwlc_pkg::ST_CHECK;
                end
            end
            pwlc_pkg::ST_CHECK: begin
                if (rx < r_v) begin
                    if (r_j == r_last) begin
                        n_res       = ry;
                        n_res_clamp = 1'b1;
                        n_state     = pwlc_pkg::ST_OUT;
                    end else begin
                        n_x0      = rx;
                        n_y0      = ry;
                        n_j       = r_j + 1'b1;
                        ram_raddr = r_j + 1'b1;
                    end
                end else if (rx == r_v) begin
                    n_res       = ry;
                    n_res_clamp = 1'b0;
                    n_state     = pwlc_pkg::ST_OUT;
                end else if (r_j == '0) begin
                    n_res       = ry;
                    n_res_clamp = 1'b1;
                    n_state     = pwlc_pkg::ST_OUT;
                end else begin
                    n_x1    = rx;
                    n_y1    = ry;
                    n_state = pwlc_pkg::ST_MUL;
                end
            end
            pwlc_pkg::ST_MUL: begin
                div_start = 1'b1;
                n_state   = pwlc_pkg::ST_DIV;
            end
            pwlc_pkg::ST_DIV: begin
                if (div_res.done) begin
                    if (interp < 0) begin
                        n_res = '0;
                    end else if (interp > $signed(SW'((1 << LW) - 1))) begin
                        n_res = '1;
                    end else begin
                        n_res = interp[LW-1:0];
                    end
                    n_res_clamp = 1'b0;
                    n_state     = pwlc_pkg::ST_OUT;
                end
            end
            pwlc_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_lut_value = r_res;
                    n_clamped   = r_res_clamp;
                    n_state     = pwlc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pwlc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pwlc_pkg::ST_IDLE;
            r_out_valid     <= 1'b0;
            r_points_in_use <= pwlc_pkg::COUNT_W'(2);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_points_in_use <= i_cfg_data;
            end
        end
        r_j         <= n_j;
        r_last      <= n_last;
        r_v         <= n_v;
        r_x0        <= n_x0;
        r_y0        <= n_y0;
        r_x1        <= n_x1;
        r_y1        <= n_y1;
        r_res       <= n_res;
        r_res_clamp <= n_res_clamp;
        r_lut_value <= n_lut_value;
        r_clamped   <= n_clamped;
    end

    assign o_out_valid = r_out_valid;
    assign o_lut_value = r_lut_value;
    assign o_clamped   = r_clamped;

endmodule

### hw/rtl/pwlc_ram.sv
module pwlc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pwlc_div.sv
module pwlc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pwlc_pkg::PROD_W-1:0]        i_dividend,
    input  logic [pwlc_pkg::LEVEL_W-1:0]       i_divisor,
    output pwlc_pkg::t_div_res                 o_res
);

    // restoring divider, one quotient bit per cycle
    logic [pwlc_pkg::DIV_STEP_W-1:0] r_cnt, n_cnt;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [pwlc_pkg::PROD_W-1:0]     r_quo, n_quo;
    logic [pwlc_pkg::LEVEL_W-1:0]    r_rem, n_rem;
    logic [pwlc_pkg::LEVEL_W-1:0]    r_dvs, n_dvs;
    logic [pwlc_pkg::LEVEL_W:0]      trial;
    logic                            ge;

    always_comb begin
        trial  = {r_rem, r_quo[pwlc_pkg::PROD_W-1]};
        ge     = (trial >= {1'b0, r_dvs});
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = pwlc_pkg::DIV_STEP_W'(pwlc_pkg::PROD_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? pwlc_pkg::LEVEL_W'(trial - {1'b0, r_dvs})
                       : trial[pwlc_pkg::LEVEL_W-1:0];
            n_quo = {r_quo[pwlc_pkg::PROD_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_quo;
    assign o_res.rem_nz   = (r_rem != '0);

endmodule

### sim/tb_piecewise_linear_curve_lut.sv
module tb_piecewise_linear_curve_lut;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   LEVEL_W        = pwlc_pkg::LEVEL_W;
    localparam int   INDEX_W        = pwlc_pkg::INDEX_W;
    localparam int   COUNT_W        = pwlc_pkg::COUNT_W;
    localparam int   MAX_POINTS_DEF = pwlc_pkg::MAX_POINTS_DEF;
    localparam logic OPC_LOAD       = pwlc_pkg::OPC_LOAD;
    localparam logic OPC_EVAL       = pwlc_pkg::OPC_EVAL;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 53;
    localparam int SETTLE_CYC  = 48;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [LEVEL_W-1:0] lut_value;
        logic               clamped;
    } t_curve_out;

    class tone_curve_checker;
        logic [LEVEL_W-1:0] x_pts [MAX_POINTS_DEF];
        logic [LEVEL_W-1:0] y_pts [MAX_POINTS_DEF];
        logic [COUNT_W-1:0] points_cfg;
        t_curve_out         expected_levels [$];
        int                 errors;
        int                 results_seen;

        function new();
            foreach (x_pts[k]) begin
                x_pts[k] = '0;
                y_pts[k] = '0;
            end
            points_cfg   = 2;
            errors       = 0;
            results_seen = 0;
        endfunction

        function int used_count();
            int n;
            n = points_cfg;
            if (n < 2) n = 2;
            if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
            return n;
        endfunction

        function logic [LEVEL_W-1:0] point_x(int k);
            return x_pts[k];
        endfunction

        function void set_points(logic [COUNT_W-1:0] v);
            points_cfg = v;
        endfunction

        function t_curve_out map_query(logic [LEVEL_W-1:0] v);
            t_curve_out res;
            int n, j, x0, x1, y0, y1, num, den, q, r;
            n = used_count();
            j = 0;
            res.clamped = 1'b0;
            while (j < n && x_pts[j] < v) j++;
            if (j >= n) begin
                res.lut_value = y_pts[n-1];
                res.clamped   = 1'b1;
            end else if (x_pts[j] == v) begin
                res.lut_value = y_pts[j];
            end else if (j == 0) begin
                res.lut_value = y_pts[0];
                res.clamped   = 1'b1;
            end else begin
                x0  = x_pts[j-1];
                x1  = x_pts[j];
                y0  = y_pts[j-1];
                y1  = y_pts[j];
                num = (int'(v) - x0) * (y1 - y0);
                den = x1 - x0;
                // floor, not truncation, for falling segments
                if (num >= 0) q = num / den;
                else q = -((-num + den - 1) / den);
                r = y0 + q;
                if (r < 0) r = 0;
                if (r > 255) r = 255;
                res.lut_value = r[LEVEL_W-1:0];
            end
            return res;
        endfunction

        function void note_input(logic op, logic [INDEX_W-1:0] idx, logic [LEVEL_W-1:0] px,
                                 logic [LEVEL_W-1:0] py, logic [LEVEL_W-1:0] qv);
            if (op == OPC_LOAD) begin
                if (idx < MAX_POINTS_DEF) begin
                    x_pts[idx] = px;
                    y_pts[idx] = py;
                end
            end else begin
                expected_levels.insert(expected_levels.size(), map_query(qv));
            end
        endfunction

        function void check_result(logic [LEVEL_W-1:0] value, logic flag);
            t_curve_out exp_out;
            results_seen++;
            if (expected_levels.size() == 0) begin
                $error("unexpected result: lut_value %0d clamped %0b", value, flag);
                errors++;
                return;
            end
            exp_out = expected_levels.pop_front();
            if (value !== exp_out.lut_value) begin
                $error("lut_value: expected %0d, actual %0d", exp_out.lut_value, value);
                errors++;
            end
            if (flag !== exp_out.clamped) begin
                $error("clamped: expected %0b, actual %0b", exp_out.clamped, flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic                 i_opcode      = OPC_LOAD;
    logic [INDEX_W-1:0]   i_point_index = '0;
    logic [LEVEL_W-1:0]   i_point_x     = '0;
    logic [LEVEL_W-1:0]   i_point_y     = '0;
    logic [LEVEL_W-1:0]   i_query_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic [LEVEL_W-1:0]   o_lut_value;
    logic                 o_clamped;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data    = '0;

    tone_curve_checker curve_chk = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int cfg_writes    = 0;
    int quiet_cycles  = 0;

    piecewise_linear_curve_lut dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_query_value (i_query_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_lut_value   (o_lut_value),
        .o_clamped     (o_clamped),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            curve_chk.check_result(o_lut_value, o_clamped);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [LEVEL_W-1:0] px, input logic [LEVEL_W-1:0] py,
                             input logic [LEVEL_W-1:0] qv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_point_index <= idx;
        i_point_x     <= px;
        i_point_y     <= py;
        i_query_value <= qv;
        do @(posedge i_clk); while (o_in_stall);
        curve_chk.note_input(op, idx, px, py, qv);
        items_sent++;
    endtask

    task automatic load_point(input int slot, input int px, input int py);
        send_item(OPC_LOAD, slot[INDEX_W-1:0], px[LEVEL_W-1:0], py[LEVEL_W-1:0],
                  LEVEL_W'($urandom));
    endtask

    task automatic eval_query(input int qv);
        send_item(OPC_EVAL, INDEX_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                  qv[LEVEL_W-1:0]);
    endtask

    // hold the input side until every pending result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (curve_chk.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_points_in_use(input logic [COUNT_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        curve_chk.set_points(v);
        cfg_writes++;
    endtask

    // ascending curve with random content over slots 0..n-1
    task automatic load_ascending_curve();
        int xs[$];
        int n;
        n = $urandom_range(2, MAX_POINTS_DEF);
        for (int k = 0; k < n; k++) xs.insert(xs.size(), $urandom_range(0, 255));
        xs.sort();
        for (int k = 0; k < n; k++) load_point(k, xs[k], $urandom_range(0, 255));
    endtask

    task automatic run_directed();
        // zigzag curve: every segment is steep, alternately rising and falling
        for (int k = 0; k < MAX_POINTS_DEF; k++) begin
            load_point(k, 10 + 16 * k, (k % 2) ? 255 : 0);
        end
        eval_query(0);      // below first point
        eval_query(255);    // above last point
        eval_query(10);     // exact first point
        eval_query(250);    // exact last point
        eval_query(11);     // rising segment
        eval_query(29);     // falling segment, floor of a negative step
        eval_query(42);
        eval_query(100);
        eval_query(137);
    endtask

    task automatic run_random(input int quota);
        int start_count;
        int pick;
        int qv;
        start_count = items_sent;
        while (items_sent - start_count < quota) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
            if (pick < 10) begin
                load_ascending_curve();
            end else if (pick < 80) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    qv = curve_chk.point_x($urandom_range(0, curve_chk.used_count() - 1));
                end else if (pick < 40) begin
                    qv = ($urandom_range(0, 1) == 1) ? 255 : 0;
                end else begin
                    qv = $urandom_range(0, 255);
                end
                eval_query(qv);
            end else begin
                // stray load, may break the ascending order
                load_point($urandom_range(0, MAX_POINTS_DEF - 1), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] cfg_plan [NUM_PHASES];
        int mode;
        cfg_plan = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd1, 5'd17, 5'd9, 5'd2};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                repeat (SETTLE_CYC) @(posedge i_clk);
            end
            write_points_in_use(cfg_plan[ph]);
            mode = ph % 4;
            send_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 33 : 0;
            stall_pct     = (mode == 2) ? 79 : (mode == 3) ? 33 : 0;
            if (ph == 0) run_directed();
            run_random(PHASE_ITEMS);
        end

        drain();
        stall_pct = 0;
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("%0d items sent (loads and evaluates), %0d results checked", items_sent,
                 curve_chk.results_seen);
        $display("%0d point-count settings from 0 to 31, four idle/stall mixes, %0d mismatches",
                 cfg_writes, curve_chk.errors);
        if (curve_chk.errors == 0 && curve_chk.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/pwlc_pkg.sv
hw/rtl/pwlc_ram.sv
hw/rtl/pwlc_div.sv
hw/rtl/piecewise_linear_curve_lut.sv
sim/tb_piecewise_linear_curve_lut.sv
